FILE: hw/rtl/pec_pkg.sv
// Shared codes, widths and the arctangent table of the polygon edge-collision block.
package pec_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_POSE   = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CS_BITS      = 20;
    localparam int ANG_BITS     = 18;
    localparam int CORDIC_START = 39797;
    localparam int QUARTER_TURN = 16384;
    localparam int HALF_TURN    = 32768;

    function automatic logic [13:0] atan_step(input logic [3:0] idx);
        logic [13:0] val;
        case (idx)
            4'd0:    val = 14'd8192;
            4'd1:    val = 14'd4836;
            4'd2:    val = 14'd2555;
            4'd3:    val = 14'd1297;
            4'd4:    val = 14'd651;
            4'd5:    val = 14'd326;
            4'd6:    val = 14'd163;
            4'd7:    val = 14'd81;
            4'd8:    val = 14'd41;
            4'd9:    val = 14'd20;
            4'd10:   val = 14'd10;
            4'd11:   val = 14'd5;
            4'd12:   val = 14'd3;
            4'd13:   val = 14'd1;
            4'd14:   val = 14'd1;
            default: val = 14'd0;
        endcase
        return val;
    endfunction

endpackage

FILE: hw/rtl/pec_cordic.sv
// Iterative CORDIC: cosine and sine of a binary angle, one step per cycle.
module pec_cordic (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start_i,
    input  logic [15:0]                        ang_i,
    output logic                               done_o,
    output logic signed [pec_pkg::CS_BITS-1:0] cos_o,
    output logic signed [pec_pkg::CS_BITS-1:0] sin_o
);
    import pec_pkg::*;

    logic signed [CS_BITS-1:0]  x_reg, y_reg, cos_reg, sin_reg;
    logic signed [ANG_BITS-1:0] z_reg;
    logic [3:0]                 it_reg;
    logic                       busy_reg, flip_reg, done_reg;

    logic signed [ANG_BITS-1:0] z_in, z_fold, atan_v;
    logic                       flip_in;
    logic signed [CS_BITS-1:0]  x_next, y_next;
    logic signed [ANG_BITS-1:0] z_next;

    always_comb begin
        z_in    = ANG_BITS'($signed(ang_i));
        z_fold  = z_in;
        flip_in = 1'b0;
        if (z_in > ANG_BITS'(QUARTER_TURN)) begin
            z_fold  = z_in - ANG_BITS'(HALF_TURN);
            flip_in = 1'b1;
        end else if (z_in < -ANG_BITS'(QUARTER_TURN)) begin
            z_fold  = z_in + ANG_BITS'(HALF_TURN);
            flip_in = 1'b1;
        end
        atan_v = ANG_BITS'(atan_step(it_reg));
        // rotate toward zero residual angle
        if (z_reg >= 0) begin
            x_next = x_reg - (y_reg >>> it_reg);
            y_next = y_reg + (x_reg >>> it_reg);
            z_next = z_reg - atan_v;
        end else begin
            x_next = x_reg + (y_reg >>> it_reg);
            y_next = y_reg - (x_reg >>> it_reg);
            z_next = z_reg + atan_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            it_reg   <= 4'd0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
                it_reg   <= 4'd0;
            end else if (busy_reg) begin
                it_reg <= it_reg + 4'd1;
                if (it_reg == 4'd15) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            x_reg    <= CS_BITS'(CORDIC_START);
            y_reg    <= '0;
            z_reg    <= z_fold;
            flip_reg <= flip_in;
        end else if (busy_reg) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
            if (it_reg == 4'd15) begin
                cos_reg <= flip_reg ? -x_next : x_next;
                sin_reg <= flip_reg ? -y_next : y_next;
            end
        end
    end

    assign done_o = done_reg;
    assign cos_o  = cos_reg;
    assign sin_o  = sin_reg;

`ifndef SYNTH
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        start_i |-> !busy_reg) else $error("cordic restarted while busy");
`endif

endmodule

FILE: hw/rtl/polygon_edge_collision.sv
// Top level: polygon store, placement and edge-crossing collision test.
//
// Input channel s_*: one beat per command. tuser selects the command (load a
// local vertex, set a polygon pose, run a test); tdata carries coordinates,
// angle and bounding radius. Load and pose beats produce no result. A test
// beat produces exactly one result beat on m_*. A test first runs the
// bounding-circle check; if the circles meet and both polygons hold vertices,
// each polygon gets its CORDIC and then has each vertex placed, then the
// edge pairs are tested, all on one shared pair of multipliers; a hit stops
// at the first crossing.
// Vertices live in one synchronous memory, placed outlines in two more.
// s_tready is high only while no test runs. The result waits in an output
// register; while it waits, load and pose beats are still taken, and a new
// test runs but holds its answer until the previous beat leaves.
// Reset clears vertex counts, poses and the overflow flag; vertex memory is
// not cleared and needs no clearing pass.
module polygon_edge_collision #(
    parameter int MAX_VERTICES = 12,
    parameter int COORD_BITS   = 24
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // coord_x, coord_y, angle[15:0], bound_radius[22:0], zero pad
    input  logic [((2*COORD_BITS+39+7)/8)*8-1:0] s_tdata,
    // op[1:0], poly_sel, vertex_first
    input  logic [3:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // collide, overflow, zero pad
    output logic [7:0] m_tdata
);
    import pec_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int W   = CB + 2;
    localparam int DW  = W + 1;
    localparam int MW  = (CB + 3 > 25) ? CB + 3 : 25;
    localparam int PW  = 2 * MW;
    localparam int IW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int VAW = $clog2(2 * MAX_VERTICES);

    typedef enum logic [16:0] {
        ST_IDLE   = 17'h00001,
        ST_B1     = 17'h00002,
        ST_B2     = 17'h00004,
        ST_B3     = 17'h00008,
        ST_CGO    = 17'h00010,
        ST_CWT    = 17'h00020,
        ST_PRD    = 17'h00040,
        ST_PM1    = 17'h00080,
        ST_PM2    = 17'h00100,
        ST_PM3    = 17'h00200,
        ST_ESTART = 17'h00400,
        ST_EA1    = 17'h00800,
        ST_EA2    = 17'h01000,
        ST_EB1    = 17'h02000,
        ST_EB     = 17'h04000,
        ST_EX     = 17'h08000,
        ST_DONE   = 17'h10000
    } pec_state_t;

    pec_state_t state_reg, state_next;

    // memories
    logic [2*CB-1:0] vmem  [2*MAX_VERTICES];
    logic [2*W-1:0]  wmem0 [MAX_VERTICES];
    logic [2*W-1:0]  wmem1 [MAX_VERTICES];
    logic [2*CB-1:0] vrd_reg;
    logic [2*W-1:0]  rd0_reg, rd1_reg;

    // polygon state
    logic [CW-1:0]          cnt_reg [2];
    logic signed [CB-1:0]   cx_reg  [2];
    logic signed [CB-1:0]   cy_reg  [2];
    logic [15:0]            ang_reg [2];
    logic [22:0]            rad_reg [2];
    logic                   ovf_reg, snap_reg, coll_reg;

    // sequencing and datapath
    logic                   pp_reg;
    logic [IW-1:0]          k_reg, i_reg, j_reg;
    logic [2:0]             cstep_reg;
    logic [3:0]             neg_reg;
    logic signed [CS_BITS-1:0] cs_reg, sn_reg;
    logic signed [W-1:0]    wx_reg;
    logic [2*W-1:0]         a1_reg, a2_reg, b1_reg, b2_reg;
    logic signed [DW-1:0]   dx_reg [4];
    logic signed [DW-1:0]   dy_reg [4];
    logic signed [PW-1:0]   p_reg, q_reg;
    logic signed [PW:0]     t_reg;
    logic                   m_valid_reg, m_coll_reg, m_ovf_reg;

    // input unpack
    logic [1:0]             in_op;
    logic                   in_sel, in_first, s_acc;
    logic signed [CB-1:0]   in_x, in_y;
    logic [15:0]            in_ang;
    logic [22:0]            in_rad;

    // cordic
    logic                   cord_start, cord_done;
    logic signed [CS_BITS-1:0] cord_cos, cord_sin;

    // combinational helpers
    logic signed [MW-1:0]   mul_a, mul_b, mul_c, mul_d;
    logic signed [MW-1:0]   bsum, bdx, bdy, vx, vy;
    logic                   r0_en, r1_en;
    logic [IW-1:0]          r0_addr, r1_addr;
    logic [CW-1:0]          i1, j1, i2, j2, eff_cnt;
    logic [VAW-1:0]         vr_addr, vw_addr;
    logic signed [PW:0]     rot_sum, cdiff;
    logic signed [PW+1:0]   bdiff;
    logic signed [W-1:0]    rot_x, rot_y;
    logic signed [W-1:0]    a1x, a1y, a2x, a2y, b1x, b1y, b2x, b2y;
    logic                   hit, out_free, edges_empty;

    assign in_op    = s_tuser[1:0];
    assign in_sel   = s_tuser[2];
    assign in_first = s_tuser[3];
    assign in_x     = $signed(s_tdata[CB-1:0]);
    assign in_y     = $signed(s_tdata[2*CB-1:CB]);
    assign in_ang   = s_tdata[2*CB+15:2*CB];
    assign in_rad   = s_tdata[2*CB+38:2*CB+16];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_ovf_reg, m_coll_reg};

    pec_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (cord_start),
        .ang_i   (ang_reg[pp_reg]),
        .done_o  (cord_done),
        .cos_o   (cord_cos),
        .sin_o   (cord_sin)
    );

    always_comb begin
        eff_cnt = in_first ? '0 : cnt_reg[in_sel];
        vw_addr = in_sel ? VAW'(MAX_VERTICES) + VAW'(eff_cnt) : VAW'(eff_cnt);
        vr_addr = pp_reg ? VAW'(MAX_VERTICES) + VAW'(k_reg) : VAW'(k_reg);

        bsum = $signed(MW'(rad_reg[0]) + MW'(rad_reg[1]));
        bdx  = MW'(cx_reg[0]) - MW'(cx_reg[1]);
        bdy  = MW'(cy_reg[0]) - MW'(cy_reg[1]);
        vx   = MW'($signed(vrd_reg[CB-1:0]));
        vy   = MW'($signed(vrd_reg[2*CB-1:CB]));

        // rounding of the rotated coordinate
        rot_sum = (PW+1)'(p_reg) - (PW+1)'(q_reg) + (PW+1)'(32768);
        rot_x   = W'(cx_reg[pp_reg]) + W'(rot_sum >>> 16);
        rot_sum = (PW+1)'(p_reg) + (PW+1)'(q_reg) + (PW+1)'(32768);
        rot_y   = W'(cy_reg[pp_reg]) + W'(rot_sum >>> 16);

        cdiff = (PW+1)'(p_reg) - (PW+1)'(q_reg);
        bdiff = (PW+2)'(t_reg) - (PW+2)'(p_reg);
        hit   = (neg_reg[0] == neg_reg[1]) && (neg_reg[2] == neg_reg[3]);
        edges_empty = (cnt_reg[0] == '0) || (cnt_reg[1] == '0);

        // closed-outline indexes: index n wraps to the first vertex
        i1 = CW'(i_reg) + CW'(1);
        i2 = CW'(i_reg) + CW'(2);
        j1 = CW'(j_reg) + CW'(1);
        j2 = CW'(j_reg) + CW'(2);

        a1x = $signed(a1_reg[W-1:0]);  a1y = $signed(a1_reg[2*W-1:W]);
        a2x = $signed(a2_reg[W-1:0]);  a2y = $signed(a2_reg[2*W-1:W]);
        b1x = $signed(b1_reg[W-1:0]);  b1y = $signed(b1_reg[2*W-1:W]);
        b2x = $signed(rd1_reg[W-1:0]); b2y = $signed(rd1_reg[2*W-1:W]);

        mul_a = '0; mul_b = '0; mul_c = '0; mul_d = '0;
        r0_en = 1'b0; r1_en = 1'b0; r0_addr = '0; r1_addr = '0;
        cord_start = 1'b0;
        state_next = state_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_acc && in_op == OP_TEST) state_next = ST_B1;
            end
            ST_B1: begin
                mul_a = bsum; mul_b = bsum; mul_c = bdx; mul_d = bdx;
                state_next = ST_B2;
            end
            ST_B2: begin
                mul_a = bdy; mul_b = bdy;
                state_next = ST_B3;
            end
            ST_B3: begin
                if (bdiff[PW+1] || edges_empty) state_next = ST_DONE;
                else state_next = ST_CGO;
            end
            ST_CGO: begin
                cord_start = 1'b1;
                state_next = ST_CWT;
            end
            ST_CWT: begin
                if (cord_done) state_next = ST_PRD;
            end
            ST_PRD: state_next = ST_PM1;
            ST_PM1: begin
                mul_a = vx; mul_b = MW'(cs_reg); mul_c = vy; mul_d = MW'(sn_reg);
                state_next = ST_PM2;
            end
            ST_PM2: begin
                mul_a = vx; mul_b = MW'(sn_reg); mul_c = vy; mul_d = MW'(cs_reg);
                state_next = ST_PM3;
            end
            ST_PM3: begin
                if (CW'(k_reg) + CW'(1) < cnt_reg[pp_reg]) state_next = ST_PRD;
                else if (!pp_reg) state_next = ST_CGO;
                else state_next = ST_ESTART;
            end
            ST_ESTART: begin
                r0_en = 1'b1;
                state_next = ST_EA1;
            end
            ST_EA1: begin
                r0_en = 1'b1;
                r0_addr = (i1 == cnt_reg[0]) ? '0 : i1[IW-1:0];
                state_next = ST_EA2;
            end
            ST_EA2: begin
                r1_en = 1'b1;
                state_next = ST_EB1;
            end
            ST_EB1: begin
                r1_en = 1'b1;
                r1_addr = (j1 == cnt_reg[1]) ? '0 : j1[IW-1:0];
                state_next = ST_EB;
            end
            ST_EB: state_next = ST_EX;
            ST_EX: begin
                case (cstep_reg)
                    3'd0: begin
                        mul_a = MW'(dx_reg[0]); mul_b = MW'(dy_reg[1]);
                        mul_c = MW'(dx_reg[1]); mul_d = MW'(dy_reg[0]);
                    end
                    3'd1: begin
                        mul_a = MW'(dx_reg[2]); mul_b = MW'(dy_reg[3]);
                        mul_c = MW'(dx_reg[3]); mul_d = MW'(dy_reg[2]);
                    end
                    3'd2: begin
                        mul_a = MW'(dx_reg[1]); mul_b = MW'(dy_reg[2]);
                        mul_c = MW'(dx_reg[2]); mul_d = MW'(dy_reg[1]);
                    end
                    3'd3: begin
                        mul_a = MW'(dx_reg[3]); mul_b = MW'(dy_reg[0]);
                        mul_c = MW'(dx_reg[0]); mul_d = MW'(dy_reg[3]);
                    end
                    default: ;
                endcase
                if (cstep_reg == 3'd5) begin
                    if (hit) begin
                        state_next = ST_DONE;
                    end else if (j1 < cnt_reg[1]) begin
                        r1_en = 1'b1;
                        r1_addr = (j2 == cnt_reg[1]) ? '0 : j2[IW-1:0];
                        state_next = ST_EB;
                    end else if (i1 < cnt_reg[0]) begin
                        r0_en = 1'b1;
                        r0_addr = (i2 == cnt_reg[0]) ? '0 : i2[IW-1:0];
                        state_next = ST_EA2;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg[0]  <= '0;
            cnt_reg[1]  <= '0;
            cx_reg[0]   <= '0;
            cx_reg[1]   <= '0;
            cy_reg[0]   <= '0;
            cy_reg[1]   <= '0;
            ang_reg[0]  <= '0;
            ang_reg[1]  <= '0;
            rad_reg[0]  <= '0;
            rad_reg[1]  <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_acc) begin
                case (in_op)
                    OP_LOAD: begin
                        if (eff_cnt < CW'(MAX_VERTICES)) cnt_reg[in_sel] <= eff_cnt + CW'(1);
                        else ovf_reg <= 1'b1;
                    end
                    OP_POSE: begin
                        cx_reg[in_sel]  <= in_x;
                        cy_reg[in_sel]  <= in_y;
                        ang_reg[in_sel] <= in_ang;
                        rad_reg[in_sel] <= in_rad;
                    end
                    OP_TEST: ovf_reg <= 1'b0;
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && out_free) m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    // memories: one write and one registered read per array
    always_ff @(posedge aclk) begin
        if (s_acc && in_op == OP_LOAD && eff_cnt < CW'(MAX_VERTICES))
            vmem[vw_addr] <= {in_y, in_x};
        if (state_reg == ST_PRD) vrd_reg <= vmem[vr_addr];
        if (state_reg == ST_PM3 && !pp_reg) wmem0[k_reg] <= {rot_y, wx_reg};
        if (state_reg == ST_PM3 && pp_reg)  wmem1[k_reg] <= {rot_y, wx_reg};
        if (r0_en) rd0_reg <= wmem0[r0_addr];
        if (r1_en) rd1_reg <= wmem1[r1_addr];
    end

    // datapath
    always_ff @(posedge aclk) begin
        p_reg <= mul_a * mul_b;
        q_reg <= mul_c * mul_d;
        if (s_acc && in_op == OP_TEST) snap_reg <= ovf_reg;
        if (state_reg == ST_DONE && out_free) begin
            m_coll_reg <= coll_reg;
            m_ovf_reg  <= snap_reg;
        end
        unique case (state_reg)
            ST_B1: coll_reg <= 1'b0;
            ST_B2: t_reg <= (PW+1)'(p_reg) - (PW+1)'(q_reg);
            ST_B3: pp_reg <= 1'b0;
            ST_CWT: begin
                if (cord_done) begin
                    cs_reg <= cord_cos;
                    sn_reg <= cord_sin;
                    k_reg  <= '0;
                end
            end
            ST_PM2: wx_reg <= rot_x;
            ST_PM3: begin
                k_reg <= k_reg + IW'(1);
                if (CW'(k_reg) + CW'(1) >= cnt_reg[pp_reg]) pp_reg <= 1'b1;
            end
            ST_ESTART: i_reg <= '0;
            ST_EA1: a1_reg <= rd0_reg;
            ST_EA2: begin
                a2_reg <= rd0_reg;
                j_reg  <= '0;
            end
            ST_EB1: b1_reg <= rd1_reg;
            ST_EB: begin
                b2_reg    <= rd1_reg;
                dx_reg[0] <= DW'(a1x) - DW'(b1x);
                dx_reg[1] <= DW'(b2x) - DW'(a1x);
                dx_reg[2] <= DW'(a2x) - DW'(b2x);
                dx_reg[3] <= DW'(b1x) - DW'(a2x);
                dy_reg[0] <= DW'(a1y) - DW'(b1y);
                dy_reg[1] <= DW'(b2y) - DW'(a1y);
                dy_reg[2] <= DW'(a2y) - DW'(b2y);
                dy_reg[3] <= DW'(b1y) - DW'(a2y);
                cstep_reg <= 3'd0;
            end
            ST_EX: begin
                cstep_reg <= cstep_reg + 3'd1;
                // zero cross product counts as positive
                if (cstep_reg != 3'd0 && cstep_reg != 3'd5)
                    neg_reg[cstep_reg[1:0] - 2'd1] <= cdiff[PW];
                if (cstep_reg == 3'd5) begin
                    if (hit) begin
                        coll_reg <= 1'b1;
                    end else if (j1 < cnt_reg[1]) begin
                        j_reg  <= j_reg + IW'(1);
                        b1_reg <= b2_reg;
                    end else if (i1 < cnt_reg[0]) begin
                        i_reg  <= i_reg + IW'(1);
                        a1_reg <= a2_reg;
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg[0] <= CW'(MAX_VERTICES)) && (cnt_reg[1] <= CW'(MAX_VERTICES)))
        else $error("vertex count past limit");
`endif
`ifndef SYNTH
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat without finished test");
`endif
`ifndef SYNTH
    a_flag_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && in_op == OP_TEST) |=> !ovf_reg)
        else $error("overflow flag not cleared by test");
`endif

endmodule
